// ===== design/letf_pkg.sv =====
// Shared types and constants for the local extremum toggle filter.
// No dependencies; imported by every module of the block.
package letf_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;
    localparam int WS_W       = 4;
    localparam int DIM_W      = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd2;

    localparam logic [WS_W-1:0]  WS_RESET     = 4'd3;
    localparam logic [DIM_W-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [DIM_W-1:0] HEIGHT_RESET = 12'd480;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_COL,
        S_ROT,
        S_DIV,
        S_FIN
    } t_state;

    // chain control: shift in a new column, or rotate the active cells
    typedef struct packed {
        logic shift;
        logic rot;
    } t_cell_ctl;

endpackage

// ===== design/letf_cell.sv =====
// One cell of the column chain: holds min, max, sum and center pixel
// of one window column. Depends on letf_pkg.
module letf_cell #(
    parameter int PIXEL_BITS = 8,
    parameter int CSUM_W     = 12
) (
    input  logic                  i_clk,
    input  letf_pkg::t_cell_ctl   i_ctl,
    input  logic                  i_tail,
    input  logic [PIXEL_BITS-1:0] i_left_min,
    input  logic [PIXEL_BITS-1:0] i_left_max,
    input  logic [CSUM_W-1:0]     i_left_sum,
    input  logic [PIXEL_BITS-1:0] i_left_ctr,
    input  logic [PIXEL_BITS-1:0] i_right_min,
    input  logic [PIXEL_BITS-1:0] i_right_max,
    input  logic [CSUM_W-1:0]     i_right_sum,
    input  logic [PIXEL_BITS-1:0] i_right_ctr,
    input  logic [PIXEL_BITS-1:0] i_head_min,
    input  logic [PIXEL_BITS-1:0] i_head_max,
    input  logic [CSUM_W-1:0]     i_head_sum,
    input  logic [PIXEL_BITS-1:0] i_head_ctr,
    output logic [PIXEL_BITS-1:0] o_min,
    output logic [PIXEL_BITS-1:0] o_max,
    output logic [CSUM_W-1:0]     o_sum,
    output logic [PIXEL_BITS-1:0] o_ctr
);
    import letf_pkg::*;

    logic [PIXEL_BITS-1:0] r_min, r_max, r_ctr;
    logic [CSUM_W-1:0]     r_sum;

    // shift from the newer neighbor side, or rotate toward the head;
    // the last active cell wraps around to take the head's column
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_min <= i_left_min;
            r_max <= i_left_max;
            r_sum <= i_left_sum;
            r_ctr <= i_left_ctr;
        end else if (i_ctl.rot) begin
            if (i_tail) begin
                r_min <= i_head_min;
                r_max <= i_head_max;
                r_sum <= i_head_sum;
                r_ctr <= i_head_ctr;
            end else begin
                r_min <= i_right_min;
                r_max <= i_right_max;
                r_sum <= i_right_sum;
                r_ctr <= i_right_ctr;
            end
        end
    end

    assign o_min = r_min;
    assign o_max = r_max;
    assign o_sum = r_sum;
    assign o_ctr = r_ctr;

endmodule

// ===== design/letf_div.sv =====
// Restoring divider, one quotient bit per cycle, for the window mean.
// Depends on letf_pkg.
module letf_div #(
    parameter int DVD_W = 18,
    parameter int DVS_W = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quotient
);
    import letf_pkg::*;

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] r_q;
    logic [DVS_W-1:0] r_rem, r_d;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy, r_done;
    logic [DVS_W:0]   rem_sh, rem_nx;
    logic             ge;

    // one restoring step
    always_comb begin
        rem_sh = {r_rem, r_q[DVD_W-1]};
        ge     = rem_sh >= {1'b0, r_d};
        rem_nx = ge ? (rem_sh - {1'b0, r_d}) : rem_sh;
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_d   <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[DVD_W-2:0], ge};
            r_rem <= rem_nx[DVS_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

// ===== design/local_extremum_toggle_filter_top.sv =====
// Local extremum toggle filter, top level.
// An item in the first n-1 rows is only written to the row store; one in the first
// n-1 columns also reads its column into the cell chain; one that completes a window
// passes through the column reads from the row store, the rotation through the cell
// chain and the bit-serial mean divider (SUM_W = 16 at defaults).
// One item at a time. Reset (synchronous, active low) restores the register
// defaults and restarts the frame; the row store needs no clearing.
module local_extremum_toggle_filter_top #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_WINDOW = 15,
    parameter int PIXEL_BITS = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [((PIXEL_BITS+7)/8)*8-1:0]     s_axis_tdata,  // [PIXEL_BITS-1:0] pixel_value
    // output stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [((PIXEL_BITS+7)/8)*8-1:0]     m_axis_tdata,  // [PIXEL_BITS-1:0] filtered_value
    output logic                                m_axis_tlast,  // last_of_frame
    // configuration writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [letf_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [letf_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import letf_pkg::*;

    localparam int TDATA_W   = ((PIXEL_BITS + 7) / 8) * 8;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int SLOT_W    = $clog2(MAX_WINDOW);
    localparam int MEM_DEPTH = 2 ** (SLOT_W + COL_W);
    localparam int NW        = $clog2(MAX_WINDOW + 1);
    localparam int NN_W      = $clog2(MAX_WINDOW * MAX_WINDOW + 1);
    localparam int CSUM_W    = PIXEL_BITS + NW;
    localparam int SUM_W     = PIXEL_BITS + NN_W;

    // ---------------- configuration ----------------
    logic [WS_W-1:0]  r_cfg_ws;
    logic [DIM_W-1:0] r_cfg_w, r_cfg_h;
    logic             cfg_acc, in_acc;

    logic [NW-1:0]    n_eff, n_m1, half;
    logic [WS_W-1:0]  n_odd;
    logic [COL_W-1:0] w_m1;
    logic [DIM_W-1:0] h_m1;

    always_comb begin
        n_odd = r_cfg_ws | WS_W'(1);
        if (32'(n_odd) > MAX_WINDOW) n_eff = NW'(MAX_WINDOW);
        else                         n_eff = NW'(n_odd);
        n_m1 = n_eff - 1'b1;
        half = n_eff >> 1;
        if (r_cfg_w == '0)                        w_m1 = '0;
        else if (32'(r_cfg_w) > MAX_WIDTH)        w_m1 = COL_W'(MAX_WIDTH - 1);
        else                                      w_m1 = COL_W'(r_cfg_w - 1'b1);
        h_m1 = (r_cfg_h == '0) ? '0 : (r_cfg_h - 1'b1);
    end

    // ---------------- state ----------------
    t_state r_state, n_state;

    logic [COL_W-1:0]  r_col;
    logic [DIM_W-1:0]  r_row;
    logic [SLOT_W-1:0] r_slot;
    logic [COL_W-1:0]  r_item_col;
    logic [SLOT_W-1:0] r_rd_slot;
    logic              r_win, r_last;
    logic [NW-1:0]     r_k;

    logic [PIXEL_BITS-1:0] mem [MEM_DEPTH];
    logic [PIXEL_BITS-1:0] r_mem_q;

    logic [PIXEL_BITS-1:0] r_cmin, r_cmax, r_cctr;
    logic [CSUM_W-1:0]     r_csum;
    logic [PIXEL_BITS-1:0] r_wmin, r_wmax, r_wctr;
    logic [SUM_W-1:0]      r_wsum;
    logic [NN_W-1:0]       r_nn;

    logic                  r_out_valid, r_out_last;
    logic [PIXEL_BITS-1:0] r_out_data;

    // control outputs of the sequencer
    logic      mem_rd, div_start, out_load, out_free;
    t_cell_ctl ctl;

    logic last_col, last_row, row_ok, col_ok;
    logic [SLOT_W:0] start_tmp;
    logic [SLOT_W-1:0] start_slot;

    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign cfg_acc  = i_cfg_valid && o_cfg_ready;
    assign out_free = !r_out_valid || m_axis_tready;

    always_comb begin
        last_col  = (r_col == w_m1);
        last_row  = (r_row == h_m1);
        row_ok    = (r_row >= DIM_W'(n_m1));
        col_ok    = (32'(r_col) >= 32'(n_m1));
        start_tmp = {1'b0, r_slot} + (SLOT_W+1)'(MAX_WINDOW) - (SLOT_W+1)'(n_m1);
        if (start_tmp >= (SLOT_W+1)'(MAX_WINDOW))
            start_slot = SLOT_W'(start_tmp - (SLOT_W+1)'(MAX_WINDOW));
        else
            start_slot = start_tmp[SLOT_W-1:0];
    end

    // ---------------- chain of cells ----------------
    logic [PIXEL_BITS-1:0] c_min [MAX_WINDOW];
    logic [PIXEL_BITS-1:0] c_max [MAX_WINDOW];
    logic [CSUM_W-1:0]     c_sum [MAX_WINDOW];
    logic [PIXEL_BITS-1:0] c_ctr [MAX_WINDOW];

    // column summary including the pixel now arriving from the store
    logic [PIXEL_BITS-1:0] col_min_nx, col_max_nx, col_ctr_nx;
    logic [CSUM_W-1:0]     col_sum_nx;

    always_comb begin
        if (r_k == NW'(1)) begin
            col_min_nx = r_mem_q;
            col_max_nx = r_mem_q;
            col_sum_nx = CSUM_W'(r_mem_q);
        end else begin
            col_min_nx = (r_mem_q < r_cmin) ? r_mem_q : r_cmin;
            col_max_nx = (r_mem_q > r_cmax) ? r_mem_q : r_cmax;
            col_sum_nx = r_csum + CSUM_W'(r_mem_q);
        end
        col_ctr_nx = ((r_k - 1'b1) == half) ? r_mem_q : r_cctr;
    end

    for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
        logic [PIXEL_BITS-1:0] l_min, l_max, l_ctr, rt_min, rt_max, rt_ctr;
        logic [CSUM_W-1:0]     l_sum, rt_sum;
        if (g == 0) begin : g_first
            assign l_min = col_min_nx;
            assign l_max = col_max_nx;
            assign l_sum = col_sum_nx;
            assign l_ctr = col_ctr_nx;
        end else begin : g_mid
            assign l_min = c_min[g-1];
            assign l_max = c_max[g-1];
            assign l_sum = c_sum[g-1];
            assign l_ctr = c_ctr[g-1];
        end
        if (g == MAX_WINDOW - 1) begin : g_end
            assign rt_min = c_min[0];
            assign rt_max = c_max[0];
            assign rt_sum = c_sum[0];
            assign rt_ctr = c_ctr[0];
        end else begin : g_inner
            assign rt_min = c_min[g+1];
            assign rt_max = c_max[g+1];
            assign rt_sum = c_sum[g+1];
            assign rt_ctr = c_ctr[g+1];
        end
        letf_cell #(
            .PIXEL_BITS (PIXEL_BITS),
            .CSUM_W     (CSUM_W)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (ctl),
            .i_tail      (n_m1 == NW'(g)),
            .i_left_min  (l_min),
            .i_left_max  (l_max),
            .i_left_sum  (l_sum),
            .i_left_ctr  (l_ctr),
            .i_right_min (rt_min),
            .i_right_max (rt_max),
            .i_right_sum (rt_sum),
            .i_right_ctr (rt_ctr),
            .i_head_min  (c_min[0]),
            .i_head_max  (c_max[0]),
            .i_head_sum  (c_sum[0]),
            .i_head_ctr  (c_ctr[0]),
            .o_min       (c_min[g]),
            .o_max       (c_max[g]),
            .o_sum       (c_sum[g]),
            .o_ctr       (c_ctr[g])
        );
    end

    // window merge of the column now at the head of the chain
    logic [PIXEL_BITS-1:0] win_min_nx, win_max_nx, win_ctr_nx;
    logic [SUM_W-1:0]      win_sum_nx;

    always_comb begin
        if (r_k == '0) begin
            win_min_nx = c_min[0];
            win_max_nx = c_max[0];
            win_sum_nx = SUM_W'(c_sum[0]);
        end else begin
            win_min_nx = (c_min[0] < r_wmin) ? c_min[0] : r_wmin;
            win_max_nx = (c_max[0] > r_wmax) ? c_max[0] : r_wmax;
            win_sum_nx = r_wsum + SUM_W'(c_sum[0]);
        end
        win_ctr_nx = (r_k == half) ? c_ctr[0] : r_wctr;
    end

    // ---------------- mean divider ----------------
    logic             div_done;
    logic [SUM_W-1:0] quot;

    letf_div #(
        .DVD_W (SUM_W),
        .DVS_W (NN_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (win_sum_nx),
        .i_divisor  (r_nn),
        .o_done     (div_done),
        .o_quotient (quot)
    );

    // ---------------- toggle decision ----------------
    logic [PIXEL_BITS-1:0] mean, pick, d_lo, d_hi, d_mean, d_pick, result;

    always_comb begin
        mean   = quot[PIXEL_BITS-1:0];
        d_lo   = r_wctr - r_wmin;
        d_hi   = r_wmax - r_wctr;
        pick   = (d_lo > d_hi) ? r_wmax : r_wmin;
        d_mean = (mean > r_wctr) ? (mean - r_wctr) : (r_wctr - mean);
        d_pick = (pick > r_wctr) ? (pick - r_wctr) : (r_wctr - pick);
        result = (d_mean <= d_pick) ? mean : pick;
    end

    // ---------------- sequencer: next state ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (in_acc && row_ok) n_state = S_COL;
            S_COL:  if (r_k == n_eff) n_state = r_win ? S_ROT : S_IDLE;
            S_ROT:  if (r_k == n_m1) n_state = S_DIV;
            S_DIV:  if (div_done) n_state = S_FIN;
            S_FIN:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // ---------------- sequencer: outputs ----------------
    always_comb begin
        s_axis_tready = 1'b0;
        o_cfg_ready   = 1'b0;
        mem_rd        = 1'b0;
        div_start     = 1'b0;
        out_load      = 1'b0;
        ctl           = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cfg_ready   = 1'b1;
                s_axis_tready = !i_cfg_valid;
            end
            S_COL: begin
                mem_rd    = (r_k < n_eff);
                ctl.shift = (r_k == n_eff);
            end
            S_ROT: begin
                ctl.rot   = 1'b1;
                div_start = (r_k == n_m1);
            end
            S_DIV: ;
            S_FIN:  out_load = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    // ---------------- config registers and position counters ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_ws <= WS_RESET;
            r_cfg_w  <= WIDTH_RESET;
            r_cfg_h  <= HEIGHT_RESET;
            r_col    <= '0;
            r_row    <= '0;
            r_slot   <= '0;
        end else if (cfg_acc) begin
            unique case (i_cfg_index)
                CFG_WINDOW_SIZE:  r_cfg_ws <= i_cfg_data[WS_W-1:0];
                CFG_IMAGE_WIDTH:  r_cfg_w  <= i_cfg_data[DIM_W-1:0];
                CFG_IMAGE_HEIGHT: r_cfg_h  <= i_cfg_data[DIM_W-1:0];
                default: ;
            endcase
            if (i_cfg_index == CFG_WINDOW_SIZE || i_cfg_index == CFG_IMAGE_WIDTH ||
                i_cfg_index == CFG_IMAGE_HEIGHT) begin
                r_col  <= '0;
                r_row  <= '0;
                r_slot <= '0;
            end
        end else if (in_acc) begin
            if (last_col) begin
                r_col <= '0;
                if (last_row) begin
                    r_row  <= '0;
                    r_slot <= '0;
                end else begin
                    r_row  <= r_row + 1'b1;
                    r_slot <= (r_slot == SLOT_W'(MAX_WINDOW - 1)) ? '0 : (r_slot + 1'b1);
                end
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    // ---------------- row store ----------------
    always_ff @(posedge i_clk) begin
        if (in_acc) mem[{r_slot, r_col}] <= s_axis_tdata[PIXEL_BITS-1:0];
        if (mem_rd) r_mem_q <= mem[{r_rd_slot, r_item_col}];
    end

    // ---------------- item datapath ----------------
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_item_col <= r_col;
            r_rd_slot  <= start_slot;
            r_win      <= col_ok;
            r_last     <= last_col && last_row;
            r_nn       <= NN_W'(n_eff * n_eff);
        end
        if (r_state == S_COL) begin
            if (mem_rd)
                r_rd_slot <= (r_rd_slot == SLOT_W'(MAX_WINDOW - 1)) ? '0 : (r_rd_slot + 1'b1);
            if (r_k != '0) begin
                r_cmin <= col_min_nx;
                r_cmax <= col_max_nx;
                r_csum <= col_sum_nx;
                r_cctr <= col_ctr_nx;
            end
        end
        if (r_state == S_ROT) begin
            r_wmin <= win_min_nx;
            r_wmax <= win_max_nx;
            r_wsum <= win_sum_nx;
            r_wctr <= win_ctr_nx;
        end
    end

    // step counter for column reads and chain rotation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= '0;
        end else if (in_acc || (r_state == S_COL && r_k == n_eff)) begin
            r_k <= '0;
        end else if (r_state == S_COL || r_state == S_ROT) begin
            r_k <= r_k + 1'b1;
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= result;
            r_out_last <= r_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = TDATA_W'(r_out_data);
    assign m_axis_tlast  = r_out_last;

endmodule

// ===== design/letf_checker.sv =====
// Port-level checks for the local extremum toggle filter, bound to the top.
// Depends on letf_pkg and local_extremum_toggle_filter_top.
module letf_checker #(
    parameter int TDATA_W = 8
) (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               s_axis_tvalid,
    input logic                               s_axis_tready,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [TDATA_W-1:0]                 m_axis_tdata,
    input logic                               m_axis_tlast,
    input logic                               i_cfg_valid,
    input logic                               o_cfg_ready
);
    import letf_pkg::*;

    // reset empties the output register
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // a result is loaded only while no item is being taken
    a_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(!(s_axis_tvalid && s_axis_tready)))
        else $error("result loaded during item intake");

    // a configuration write never coincides with an item
    a_cfg_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid && o_cfg_ready |-> !s_axis_tready)
        else $error("item taken with configuration write");

endmodule

bind local_extremum_toggle_filter_top letf_checker #(.TDATA_W(TDATA_W)) u_letf_checker (.*);

// ===== verif/tb_local_extremum_toggle_filter_top.sv =====
// Self-checking testbench for local_extremum_toggle_filter_top: streams pixel
// planes, predicts each interior result and compares it on the output stream.
// Depends on letf_pkg and the RTL of the block only.
`timescale 1ns / 100ps

module tb_local_extremum_toggle_filter_top;
    import letf_pkg::*;

    localparam int CLK_HALF   = 10;
    localparam int MAXW       = 2048;
    localparam int MAXN       = 15;
    localparam int DRAIN_CYC  = 200;
    localparam int STALL_LIM  = 6000;
    localparam int HOLD_CYC   = 400;
    localparam int RAND_ITEMS = 1280;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct {
        logic [7:0] value;
        logic       last;
    } t_filt_res;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [7:0]            m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // pixel queue for the driver, expected filter outputs
    logic [7:0] pix_q[$];
    t_filt_res  filt_q[$];

    // predictor copy of the block state
    logic [7:0]       line_mem[MAXN][MAXW];
    logic [WS_W-1:0]  p_ws;
    logic [DIM_W-1:0] p_wid, p_hei;
    int               p_col, p_row;

    int  tx_idle_pct = 13, rx_idle_pct = 57;
    logic hold_go = 1'b0;
    int  hold_cnt = 0;
    logic in_took = 1'b0;
    int  idle_cyc = 0;
    int  err_cnt = 0, n_pix = 0, n_res = 0, n_cfg = 0, n_rand = 0;

    local_extremum_toggle_filter_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [7:0] pixel_value
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [7:0] filtered_value
        .m_axis_tlast  (m_axis_tlast),   // last_of_frame
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    task automatic report(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d, expected %0d (result %0d)", what, got, want, n_res);
        err_cnt++;
    endtask

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_WINDOW_SIZE:  p_ws = val[WS_W-1:0];
            CFG_IMAGE_WIDTH:  p_wid = val;
            CFG_IMAGE_HEIGHT: p_hei = val;
            default: return;
        endcase
        p_col = 0;
        p_row = 0;
    endfunction

    // extremum toggle on the window ending at the current pixel
    function automatic void filter_pixel(input logic [7:0] pix);
        int n, w, h, col, row, half, lo, hi, sum, v, ctr, mean, pick, d0, d1;
        t_filt_res r;
        n = p_ws | 1;
        if (n > MAXN) n = MAXN;
        w = (p_wid == 0) ? 1 : ((p_wid > MAXW) ? MAXW : int'(p_wid));
        h = (p_hei == 0) ? 1 : int'(p_hei);
        col = (p_col >= w) ? w - 1 : p_col;
        row = (p_row >= h) ? h - 1 : p_row;
        line_mem[row % MAXN][col] = pix;
        if (row + 1 >= n && col + 1 >= n) begin
            half = n / 2;
            lo = 255;
            hi = 0;
            sum = 0;
            for (int ky = 0; ky < n; ky++)
                for (int kx = 0; kx < n; kx++) begin
                    v = line_mem[(row + 1 - n + ky) % MAXN][col + 1 - n + kx];
                    if (v > hi) hi = v;
                    if (v < lo) lo = v;
                    sum += v;
                end
            ctr = line_mem[(row + 1 - n + half) % MAXN][col + 1 - n + half];
            mean = sum / (n * n);
            pick = (ctr - lo > hi - ctr) ? hi : lo;
            d0 = (mean > ctr) ? mean - ctr : ctr - mean;
            d1 = (pick > ctr) ? pick - ctr : ctr - pick;
            if (d0 <= d1) pick = mean;
            r.value = pick[7:0];
            r.last = (col == w - 1) && (row == h - 1);
            filt_q.push_back(r);
        end
        if (col == w - 1) begin
            p_col = 0;
            p_row = (row == h - 1) ? 0 : row + 1;
        end else begin
            p_col = col + 1;
            p_row = row;
        end
    endfunction

    // pixel driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_took) begin
            if (pix_q.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= pix_q.pop_front();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // long receiver hold-off counter
    always @(negedge i_clk) begin
        if (hold_go) hold_cnt <= HOLD_CYC;
        else if (hold_cnt > 0) hold_cnt <= hold_cnt - 1;
    end

    // output ready
    always @(negedge i_clk) begin
        m_axis_tready <= (hold_cnt == 0) && ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // monitor, predictor and watchdog
    always @(posedge i_clk) begin
        t_filt_res e;
        in_took <= s_axis_tvalid && s_axis_tready;
        if (i_rst_n && i_cfg_valid && o_cfg_ready) begin
            apply_reg(i_cfg_index, i_cfg_data);
            n_cfg++;
        end
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            filter_pixel(s_axis_tdata);
            n_pix++;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (filt_q.size() == 0) begin
                report("unexpected result", m_axis_tdata, -1);
            end else begin
                e = filt_q.pop_front();
                if (m_axis_tdata !== e.value) report("filtered_value", m_axis_tdata, e.value);
                if (m_axis_tlast !== e.last) report("last_of_frame", m_axis_tlast, e.last);
            end
            n_res++;
        end
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready))
            idle_cyc <= 0;
        else
            idle_cyc <= idle_cyc + 1;
        if (idle_cyc >= STALL_LIM) begin
            $display("watchdog: no progress for %0d cycles", STALL_LIM);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic wait_idle();
        while (pix_q.size() > 0 || s_axis_tvalid || filt_q.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_plane(input int ws, input int wid, input int hei);
        wait_idle();
        write_reg(CFG_WINDOW_SIZE, CFG_DATA_W'(ws));
        write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(wid));
        write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'(hei));
    endtask

    initial begin
        int n, w, h, cnt, base, span;
        logic [7:0] dir_pix[16];
        p_ws  = WS_RESET;
        p_wid = WIDTH_RESET;
        p_hei = HEIGHT_RESET;
        p_col = 0;
        p_row = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes and ties in a 4x4 plane, window 3
        set_plane(3, 4, 4);
        dir_pix = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd255, 8'd128, 8'd0, 8'd1,
                    8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd127};
        foreach (dir_pix[i])
            pix_q.push_back(dir_pix[i]);
        // window of one, zero width and height treated as one
        set_plane(12'hFF0, 0, 0);
        pix_q.push_back(8'h55);
        pix_q.push_back(8'hAA);
        pix_q.push_back(8'hFF);
        // window larger than the image: no results; spare index has no effect
        set_plane(9, 5, 3);
        write_reg(CFG_SPARE, 12'hFFF);
        repeat (6) pix_q.push_back(8'($urandom_range(0, 255)));
        // wide row, clamped width, window of one
        set_plane(0, 4095, 1);
        repeat (40) pix_q.push_back(8'($urandom_range(0, 255)));
        // tallest plane, part of it only
        set_plane(1, 1, 4095);
        repeat (40) pix_q.push_back(8'($urandom_range(0, 255)));

        // random planes, mostly complete frames
        while (n_rand < RAND_ITEMS) begin
            if (n_rand < RAND_ITEMS / 3) begin
                tx_idle_pct = 13;
                rx_idle_pct = 57;
            end else if (n_rand < 2 * RAND_ITEMS / 3) begin
                tx_idle_pct = 57;
                rx_idle_pct = 13;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            n = $urandom_range(0, 15);
            if ($urandom_range(0, 3) == 0) n = 15;
            if ($urandom_range(0, 2) != 0) n = $urandom_range(0, 5);
            w = (n | 1) + $urandom_range(0, 10);
            h = (n | 1) + $urandom_range(0, 6);
            if ($urandom_range(0, 9) == 0) w = $urandom_range(1, n | 1);
            set_plane(n + 16 * int'($urandom_range(0, 255)), w, h);
            cnt = w * h * $urandom_range(1, 2);
            if ($urandom_range(0, 4) == 0) cnt = $urandom_range(1, cnt);
            if (cnt > 600) cnt = 600;
            if (cnt > RAND_ITEMS - n_rand) cnt = RAND_ITEMS - n_rand;
            span = (1 << $urandom_range(1, 8)) - 1;
            base = $urandom_range(0, 255 - span);
            repeat (cnt) pix_q.push_back(8'(base + $urandom_range(0, span)));
            n_rand += cnt;
        end

        // receiver held off while a full plane keeps streaming in
        set_plane(3, 8, 8);
        @(negedge i_clk) hold_go <= 1'b1;
        @(negedge i_clk) hold_go <= 1'b0;
        repeat (64) pix_q.push_back(8'($urandom_range(0, 255)));

        wait_idle();
        $display("Covered %0d pixels and %0d filtered results over %0d register writes,",
                 n_pix, n_res, n_cfg);
        $display("windows 1 to 15, widths 0 to 4095, heights 0 to 4095, with stalls.");
        if (err_cnt == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches", err_cnt);
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
